// ===== src/ctc_pkg.sv =====
package ctc_pkg;

  localparam int PIX_W   = 16;
  localparam int COORD_W = 10;
  localparam int COUNT_W = 21;
  localparam int SUM_W   = 30;
  localparam int CHAN_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COUNT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

  // Luma weights, sum to 256.
  localparam logic [7:0] LUMA_R = 8'd54;
  localparam logic [7:0] LUMA_G = 8'd183;
  localparam logic [7:0] LUMA_B = 8'd19;

  // Reset values of the configuration registers.
  localparam logic [CHAN_W-1:0]  RED_LOW_RST    = 8'd60;
  localparam logic [CHAN_W-1:0]  RED_HIGH_RST   = 8'd100;
  localparam logic [CHAN_W-1:0]  GREEN_LOW_RST  = 8'd0;
  localparam logic [CHAN_W-1:0]  GREEN_HIGH_RST = 8'd40;
  localparam logic [CHAN_W-1:0]  BLUE_LOW_RST   = 8'd20;
  localparam logic [CHAN_W-1:0]  BLUE_HIGH_RST  = 8'd60;
  localparam logic [COUNT_W-1:0] MIN_MATCH_RST  = 21'd100;

  // One quotient bit per step over the whole sum.
  localparam int DIV_STEPS = SUM_W;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RED_LOW    = 3'd0,
    CFG_RED_HIGH   = 3'd1,
    CFG_GREEN_LOW  = 3'd2,
    CFG_GREEN_HIGH = 3'd3,
    CFG_BLUE_LOW   = 3'd4,
    CFG_BLUE_HIGH  = 3'd5,
    CFG_MIN_MATCH  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_low;
    logic [CHAN_W-1:0] red_high;
    logic [CHAN_W-1:0] green_low;
    logic [CHAN_W-1:0] green_high;
    logic [CHAN_W-1:0] blue_low;
    logic [CHAN_W-1:0] blue_high;
  } window_t;

  // One classified pixel on its way from the front to the back.
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic               matched;
    logic               eof;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   row_sum;
    logic [SUM_W-1:0]   column_sum;
  } entry_t;

endpackage

// ===== src/ctc_in_if.sv =====
interface ctc_in_if;
  logic                          valid;
  logic                          ready;
  logic [ctc_pkg::PIX_W-1:0]     pixel_value;
  logic [ctc_pkg::COORD_W-1:0]   row;
  logic [ctc_pkg::COORD_W-1:0]   column;
  logic                          end_of_frame;

  modport source (output valid, pixel_value, row, column, end_of_frame, input ready);
  modport sink   (input valid, pixel_value, row, column, end_of_frame, output ready);
endinterface

// ===== src/ctc_out_if.sv =====
interface ctc_out_if;
  logic                          valid;
  logic                          ready;
  logic [ctc_pkg::PIX_W-1:0]     out_pixel;
  logic                          pixel_matched;
  logic                          frame_done;
  logic                          object_found;
  logic [ctc_pkg::COORD_W-1:0]   centroid_row;
  logic [ctc_pkg::COORD_W-1:0]   centroid_column;
  logic [ctc_pkg::COUNT_W-1:0]   match_count;

  modport source (output valid, out_pixel, pixel_matched, frame_done, object_found,
                  centroid_row, centroid_column, match_count, input ready);
  modport sink   (input valid, out_pixel, pixel_matched, frame_done, object_found,
                  centroid_row, centroid_column, match_count, output ready);
endinterface

// ===== src/ctc_front.sv =====
module ctc_front (
  input  logic                clk,
  input  logic                rst_n,
  ctc_in_if.sink              in_ch,
  input  ctc_pkg::window_t    window,
  input  logic                queue_full,
  output logic                push,
  output ctc_pkg::entry_t     push_data
);

  logic [ctc_pkg::CHAN_W-1:0]  red, green, blue;
  logic                        hit;
  logic [15:0]                 luma_sum;
  logic [7:0]                  grey;
  logic [ctc_pkg::COUNT_W-1:0] count_r, count_nxt, count_upd;
  logic [ctc_pkg::SUM_W-1:0]   row_sum_r, row_sum_nxt, row_sum_upd;
  logic [ctc_pkg::SUM_W-1:0]   col_sum_r, col_sum_nxt, col_sum_upd;
  logic [ctc_pkg::SUM_W:0]     row_ext, col_ext;

  assign in_ch.ready = !queue_full;
  assign push        = in_ch.valid && !queue_full;

  // Expand to 8-bit channels with zero fill.
  assign red   = {in_ch.pixel_value[15:11], 3'b000};
  assign green = {in_ch.pixel_value[10:5], 2'b00};
  assign blue  = {in_ch.pixel_value[4:0], 3'b000};

  assign hit = (window.red_low < red)     && (red < window.red_high) &&
               (window.green_low < green) && (green < window.green_high) &&
               (window.blue_low < blue)   && (blue < window.blue_high);

  // The weighted sum of the largest codes stays below 2^16.
  assign luma_sum = ({8'b0, red} * {8'b0, ctc_pkg::LUMA_R}) +
                    ({8'b0, green} * {8'b0, ctc_pkg::LUMA_G}) +
                    ({8'b0, blue} * {8'b0, ctc_pkg::LUMA_B});
  assign grey     = luma_sum[15:8];

  // Saturating accumulation of the matched pixel.
  assign row_ext = {1'b0, row_sum_r} + {{(ctc_pkg::SUM_W+1-ctc_pkg::COORD_W){1'b0}}, in_ch.row};
  assign col_ext = {1'b0, col_sum_r} + {{(ctc_pkg::SUM_W+1-ctc_pkg::COORD_W){1'b0}}, in_ch.column};

  always_comb begin
    count_upd   = count_r;
    row_sum_upd = row_sum_r;
    col_sum_upd = col_sum_r;
    if (hit) begin
      count_upd   = (count_r == ctc_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;
      row_sum_upd = row_ext[ctc_pkg::SUM_W] ? ctc_pkg::SUM_MAX : row_ext[ctc_pkg::SUM_W-1:0];
      col_sum_upd = col_ext[ctc_pkg::SUM_W] ? ctc_pkg::SUM_MAX : col_ext[ctc_pkg::SUM_W-1:0];
    end
  end

  always_comb begin
    count_nxt   = count_r;
    row_sum_nxt = row_sum_r;
    col_sum_nxt = col_sum_r;
    if (push) begin
      if (in_ch.end_of_frame) begin
        count_nxt   = '0;
        row_sum_nxt = '0;
        col_sum_nxt = '0;
      end else begin
        count_nxt   = count_upd;
        row_sum_nxt = row_sum_upd;
        col_sum_nxt = col_sum_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      row_sum_r <= '0;
      col_sum_r <= '0;
    end else begin
      count_r   <= count_nxt;
      row_sum_r <= row_sum_nxt;
      col_sum_r <= col_sum_nxt;
    end
  end

  always_comb begin
    push_data.pixel      = hit ? in_ch.pixel_value : {grey[7:3], grey[7:2], grey[7:3]};
    push_data.matched    = hit;
    push_data.eof        = in_ch.end_of_frame;
    push_data.count      = count_upd;
    push_data.row_sum    = row_sum_upd;
    push_data.column_sum = col_sum_upd;
  end

endmodule

// ===== src/ctc_queue.sv =====
module ctc_queue #(
  parameter int DEPTH = ctc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ctc_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output ctc_pkg::entry_t pop_data,
  output logic            empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ctc_pkg::entry_t   slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  fill_r;

  assign full     = (fill_r == CNT_W'(DEPTH));
  assign empty    = (fill_r == '0);
  assign pop_data = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/ctc_back.sv =====
module ctc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ctc_pkg::COUNT_W-1:0] min_match_count,
  input  logic                        empty,
  input  ctc_pkg::entry_t             head,
  output logic                        pop,
  ctc_out_if.source                   out_ch
);

  localparam int STEP_W = $clog2(ctc_pkg::DIV_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD
  } state_t;

  state_t                      state_r;
  logic                        out_valid_r;
  logic [STEP_W-1:0]           step_r;
  ctc_pkg::entry_t             hold_r;
  logic [ctc_pkg::COUNT_W-1:0] rem_row_r, rem_col_r;
  logic [ctc_pkg::SUM_W-1:0]   quo_row_r, quo_col_r;

  logic [ctc_pkg::PIX_W-1:0]   pixel_r;
  logic                        matched_r, done_r, found_r;
  logic [ctc_pkg::COORD_W-1:0] cent_row_r, cent_col_r;
  logic [ctc_pkg::COUNT_W-1:0] match_cnt_r;

  logic                        out_free, need_div, load_out;
  logic [ctc_pkg::COUNT_W:0]   trial_row, trial_col, diff_row, diff_col, divisor;
  logic                        ge_row, ge_col;

  assign out_free = !out_valid_r || out_ch.ready;
  assign need_div = head.eof && (head.count > min_match_count);
  assign pop      = (state_r == ST_IDLE) && !empty && (need_div || out_free);

  // The output register takes a new beat straight from the queue or after a division.
  assign load_out = ((state_r == ST_IDLE) && pop && !need_div) ||
                    ((state_r == ST_LOAD) && out_free);

  // One restoring division step per cycle on both sums.
  assign divisor   = {1'b0, hold_r.count};
  assign trial_row = {rem_row_r, quo_row_r[ctc_pkg::SUM_W-1]};
  assign trial_col = {rem_col_r, quo_col_r[ctc_pkg::SUM_W-1]};
  assign diff_row  = trial_row - divisor;
  assign diff_col  = trial_col - divisor;
  assign ge_row    = trial_row >= divisor;
  assign ge_col    = trial_col >= divisor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      out_valid_r <= load_out || (out_valid_r && !out_ch.ready);
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            if (need_div) begin
              hold_r    <= head;
              rem_row_r <= '0;
              rem_col_r <= '0;
              quo_row_r <= head.row_sum;
              quo_col_r <= head.column_sum;
              step_r    <= '0;
              state_r   <= ST_DIV;
            end else begin
              pixel_r     <= head.pixel;
              matched_r   <= head.matched;
              done_r      <= head.eof;
              found_r     <= 1'b0;
              cent_row_r  <= '0;
              cent_col_r  <= '0;
              match_cnt_r <= head.eof ? head.count : '0;
            end
          end
        end
        ST_DIV: begin
          rem_row_r <= ge_row ? diff_row[ctc_pkg::COUNT_W-1:0] : trial_row[ctc_pkg::COUNT_W-1:0];
          rem_col_r <= ge_col ? diff_col[ctc_pkg::COUNT_W-1:0] : trial_col[ctc_pkg::COUNT_W-1:0];
          quo_row_r <= {quo_row_r[ctc_pkg::SUM_W-2:0], ge_row};
          quo_col_r <= {quo_col_r[ctc_pkg::SUM_W-2:0], ge_col};
          step_r    <= step_r + 1'b1;
          if (step_r == STEP_W'(ctc_pkg::DIV_STEPS - 1)) begin
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            pixel_r     <= hold_r.pixel;
            matched_r   <= hold_r.matched;
            done_r      <= 1'b1;
            found_r     <= 1'b1;
            cent_row_r  <= (quo_row_r[ctc_pkg::SUM_W-1:ctc_pkg::COORD_W] != '0) ?
                           ctc_pkg::COORD_MAX : quo_row_r[ctc_pkg::COORD_W-1:0];
            cent_col_r  <= (quo_col_r[ctc_pkg::SUM_W-1:ctc_pkg::COORD_W] != '0) ?
                           ctc_pkg::COORD_MAX : quo_col_r[ctc_pkg::COORD_W-1:0];
            match_cnt_r <= hold_r.count;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_pixel       = pixel_r;
  assign out_ch.pixel_matched   = matched_r;
  assign out_ch.frame_done      = done_r;
  assign out_ch.object_found    = found_r;
  assign out_ch.centroid_row    = cent_row_r;
  assign out_ch.centroid_column = cent_col_r;
  assign out_ch.match_count     = match_cnt_r;

endmodule

// ===== src/color_threshold_centroid.sv =====
// A beat goes through the queue into the output register; an end-of-frame beat that reports
// an object first runs the divider. Throughput: one pixel per cycle while the output is not
// stalled, except that each reported object holds the back end for 30 divider steps and a
// load while the queue takes in pixels until it is full.
// Reset (synchronous, rst_n low) empties the queue, clears the accumulators and output
// valid, and loads the window and minimum-count registers with their default values.
module color_threshold_centroid #(
  parameter int QUEUE_DEPTH = ctc_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ctc_in_if.sink                         in_stream,
  ctc_out_if.source                      out_stream,
  input  logic                           cfg_we,
  input  logic [ctc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers. The user must write them only while idle (not enforced by the block),
  // so the front and back ends may use them directly without any shadowing.
  ctc_pkg::window_t            window_r;
  logic [ctc_pkg::COUNT_W-1:0] min_match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r.red_low    <= ctc_pkg::RED_LOW_RST;
      window_r.red_high   <= ctc_pkg::RED_HIGH_RST;
      window_r.green_low  <= ctc_pkg::GREEN_LOW_RST;
      window_r.green_high <= ctc_pkg::GREEN_HIGH_RST;
      window_r.blue_low   <= ctc_pkg::BLUE_LOW_RST;
      window_r.blue_high  <= ctc_pkg::BLUE_HIGH_RST;
      min_match_r         <= ctc_pkg::MIN_MATCH_RST;
    end else if (cfg_we) begin
      unique case (ctc_pkg::cfg_idx_t'(cfg_index))
        ctc_pkg::CFG_RED_LOW:    window_r.red_low    <= cfg_wdata[ctc_pkg::CHAN_W-1:0];
        ctc_pkg::CFG_RED_HIGH:   window_r.red_high   <= cfg_wdata[ctc_pkg::CHAN_W-1:0];
        ctc_pkg::CFG_GREEN_LOW:  window_r.green_low  <= cfg_wdata[ctc_pkg::CHAN_W-1:0];
        ctc_pkg::CFG_GREEN_HIGH: window_r.green_high <= cfg_wdata[ctc_pkg::CHAN_W-1:0];
        ctc_pkg::CFG_BLUE_LOW:   window_r.blue_low   <= cfg_wdata[ctc_pkg::CHAN_W-1:0];
        ctc_pkg::CFG_BLUE_HIGH:  window_r.blue_high  <= cfg_wdata[ctc_pkg::CHAN_W-1:0];
        ctc_pkg::CFG_MIN_MATCH:  min_match_r         <= cfg_wdata;
        // An index beyond the register list is ignored.
        default: ;
      endcase
    end
  end

  logic            push, pop, full, empty;
  ctc_pkg::entry_t push_data, head;

  // The front end classifies each pixel, builds the grey replacement and keeps the
  // running count and coordinate sums. On an end-of-frame beat it passes the totals,
  // including that beat's own contribution, down the queue and clears them.
  ctc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_stream),
    .window     (window_r),
    .queue_full (full),
    .push       (push),
    .push_data  (push_data)
  );

  // The queue decouples the pixel stream from the divider, so pixels keep flowing
  // while a centroid is being worked out, until the queue is full.
  ctc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  // The back end owns the output register. Ordinary beats go straight into it; an
  // end-of-frame beat whose count exceeds the minimum first runs the two divisions,
  // whose quotients are clamped to the largest coordinate.
  ctc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .min_match_count (min_match_r),
    .empty           (empty),
    .head            (head),
    .pop             (pop),
    .out_ch          (out_stream)
  );

endmodule

// ===== test/centroid_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the segmentation block, predicts each result beat
// from the accepted pixel beats and the register writes, and compares them.
module centroid_checker
  import ctc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ctc_in_if                     in_mon,
  ctc_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    results_owed
);

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic               matched;
    logic               frame_done;
    logic               object_found;
    logic [COORD_W-1:0] centroid_row;
    logic [COORD_W-1:0] centroid_column;
    logic [COUNT_W-1:0] count;
  } segment_result_t;

  window_t            window;
  logic [COUNT_W-1:0] min_matches;
  logic [COUNT_W-1:0] matched_pixels;
  logic [SUM_W-1:0]   row_total;
  logic [SUM_W-1:0]   column_total;
  segment_result_t    segmented_pixels[$];

  function automatic logic in_window(input logic [CHAN_W-1:0] v, lo, hi);
    return (lo < v) && (v < hi);
  endfunction

  function automatic logic [SUM_W-1:0] add_saturated(input logic [SUM_W-1:0] acc,
                                                     input logic [COORD_W-1:0] add);
    if (acc > SUM_MAX - add) return SUM_MAX;
    return acc + add;
  endfunction

  function automatic logic [COORD_W-1:0] floor_mean(input logic [SUM_W-1:0] total,
                                                    input logic [COUNT_W-1:0] count);
    logic [SUM_W-1:0] quotient;
    quotient = total / count;
    return (quotient > COORD_MAX) ? COORD_MAX : quotient[COORD_W-1:0];
  endfunction

  // Classifies one pixel and updates the frame accumulators.
  function automatic segment_result_t segment_pixel(input logic [PIX_W-1:0] pix,
                                                    input logic [COORD_W-1:0] row, col,
                                                    input logic eof);
    logic [CHAN_W-1:0] red, green, blue, grey;
    int                luma;
    segment_result_t   res;
    red   = {pix[15:11], 3'b000};
    green = {pix[10:5], 2'b00};
    blue  = {pix[4:0], 3'b000};
    res = '0;
    res.frame_done = eof;
    res.matched = in_window(red, window.red_low, window.red_high) &&
                  in_window(green, window.green_low, window.green_high) &&
                  in_window(blue, window.blue_low, window.blue_high);
    if (res.matched) begin
      res.pixel = pix;
      if (matched_pixels != COUNT_MAX) matched_pixels = matched_pixels + 1'b1;
      row_total    = add_saturated(row_total, row);
      column_total = add_saturated(column_total, col);
    end else begin
      luma = int'(LUMA_R) * red + int'(LUMA_G) * green + int'(LUMA_B) * blue;
      grey = 8'(luma >> 8);
      res.pixel = {grey[7:3], grey[7:2], grey[7:3]};
    end
    if (eof) begin
      res.count = matched_pixels;
      if (matched_pixels > min_matches) begin
        res.object_found    = 1'b1;
        res.centroid_row    = floor_mean(row_total, matched_pixels);
        res.centroid_column = floor_mean(column_total, matched_pixels);
      end
      matched_pixels = '0;
      row_total      = '0;
      column_total   = '0;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    segment_result_t want;
    if (!rst_n) begin
      segmented_pixels.delete();
      window.red_low    = RED_LOW_RST;
      window.red_high   = RED_HIGH_RST;
      window.green_low  = GREEN_LOW_RST;
      window.green_high = GREEN_HIGH_RST;
      window.blue_low   = BLUE_LOW_RST;
      window.blue_high  = BLUE_HIGH_RST;
      min_matches    = MIN_MATCH_RST;
      matched_pixels = '0;
      row_total      = '0;
      column_total   = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RED_LOW:    window.red_low    = cfg_wdata[CHAN_W-1:0];
          CFG_RED_HIGH:   window.red_high   = cfg_wdata[CHAN_W-1:0];
          CFG_GREEN_LOW:  window.green_low  = cfg_wdata[CHAN_W-1:0];
          CFG_GREEN_HIGH: window.green_high = cfg_wdata[CHAN_W-1:0];
          CFG_BLUE_LOW:   window.blue_low   = cfg_wdata[CHAN_W-1:0];
          CFG_BLUE_HIGH:  window.blue_high  = cfg_wdata[CHAN_W-1:0];
          CFG_MIN_MATCH:  min_matches       = cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (segmented_pixels.size() == 0) begin
          $error("result beat with no pixel waiting for it");
          fail_count++;
        end else begin
          want = segmented_pixels.pop_front();
          check_field("out_pixel", want.pixel, out_mon.out_pixel);
          check_field("pixel_matched", want.matched, out_mon.pixel_matched);
          check_field("frame_done", want.frame_done, out_mon.frame_done);
          check_field("object_found", want.object_found, out_mon.object_found);
          check_field("centroid_row", want.centroid_row, out_mon.centroid_row);
          check_field("centroid_column", want.centroid_column, out_mon.centroid_column);
          check_field("match_count", want.count, out_mon.match_count);
        end
      end
      if (in_mon.valid && in_mon.ready)
        segmented_pixels.push_back(segment_pixel(in_mon.pixel_value, in_mon.row,
                                                 in_mon.column, in_mon.end_of_frame));
    end
    results_owed = segmented_pixels.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// Top of the segmentation testbench. It drives the pixel stream, the output
// stall pattern and the register writes; all prediction and comparison lives
// in the checker instantiated beside the block.
module testbench;
  import ctc_pkg::*;

  // Index 7 decodes to no register, so a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 100;

  typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_e;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    results_owed;

  // The stimulus keeps its own copy of the windows so that it can aim pixels
  // inside them. Entry 0 is red, 1 green, 2 blue.
  logic [CHAN_W-1:0] chan_lo[3];
  logic [CHAN_W-1:0] chan_hi[3];

  int          burst_left;
  int          stall_left;
  ready_mode_e stall_mode;
  logic [7:0]  stall_tick;

  ctc_in_if  in_ch();
  ctc_out_if out_ch();

  color_threshold_centroid DUT (
    .clk,
    .rst_n,
    .in_stream  (in_ch),
    .out_stream (out_ch),
    .cfg_we,
    .cfg_index,
    .cfg_wdata
  );

  centroid_checker result_check (
    .clk,
    .rst_n,
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we,
    .cfg_index,
    .cfg_wdata,
    .fail_count,
    .results_owed
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver switches between stall patterns every so often: fully ready
  // stretches, coin flips, mostly stalled, and a fixed one-in-four stall.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(1, 120);
      stall_mode = ready_mode_e'($urandom_range(3));
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      READY_ALWAYS: out_ch.ready <= 1'b1;
      READY_COIN:   out_ch.ready <= 1'($urandom_range(1));
      READY_SPARSE: out_ch.ready <= ($urandom_range(3) == 0);
      default:      out_ch.ready <= (stall_tick[1:0] != 2'd0);
    endcase
  end

  // Sends one pixel beat. The sender works in bursts; between bursts it usually
  // drops valid for a gap, though some bursts follow with no gap at all.
  // Called at a falling edge, and returns at the falling edge after the beat
  // was taken.
  task automatic send_beat(input logic [PIX_W-1:0] pix, input logic [COORD_W-1:0] row, col,
                           input logic eof);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.pixel_value  <= pix;
    in_ch.row          <= row;
    in_ch.column       <= col;
    in_ch.end_of_frame <= eof;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Stops the pixel stream and waits until every accepted beat has come out.
  // Every pixel yields exactly one result, so nothing is left in flight then.
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  // One register write per falling edge; cfg_we is lowered by the caller once
  // the whole set is written.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_RED_LOW:    chan_lo[0] = data[CHAN_W-1:0];
      CFG_RED_HIGH:   chan_hi[0] = data[CHAN_W-1:0];
      CFG_GREEN_LOW:  chan_lo[1] = data[CHAN_W-1:0];
      CFG_GREEN_HIGH: chan_hi[1] = data[CHAN_W-1:0];
      CFG_BLUE_LOW:   chan_lo[2] = data[CHAN_W-1:0];
      CFG_BLUE_HIGH:  chan_hi[2] = data[CHAN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Rewrites every register while the block is idle. The window registers are
  // eight bits wide, so the upper data bits carry random junk that the block
  // must drop. A write to the unused index follows each set.
  task automatic apply_settings(input logic [CHAN_W-1:0] r_lo, r_hi, g_lo, g_hi, b_lo, b_hi,
                                input logic [CFG_DATA_W-1:0] min_count);
    wait_results_done();
    write_reg(CFG_RED_LOW,    {13'($urandom), r_lo});
    write_reg(CFG_RED_HIGH,   {13'($urandom), r_hi});
    write_reg(CFG_GREEN_LOW,  {13'($urandom), g_lo});
    write_reg(CFG_GREEN_HIGH, {13'($urandom), g_hi});
    write_reg(CFG_BLUE_LOW,   {13'($urandom), b_lo});
    write_reg(CFG_BLUE_HIGH,  {13'($urandom), b_hi});
    write_reg(CFG_MIN_MATCH,  min_count);
    write_reg(CFG_UNUSED_INDEX, 21'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Picks a channel code whose expanded value falls inside the current window,
  // or any code when the window is empty.
  function automatic int pick_channel(input int ch);
    int bits;
    int code;
    int fits[$];
    bits = (ch == 1) ? 6 : 5;
    for (code = 0; code < (1 << bits); code++)
      if (chan_lo[ch] < (code << (8 - bits)) && (code << (8 - bits)) < chan_hi[ch])
        fits.push_back(code);
    if (fits.size() == 0) return $urandom_range((1 << bits) - 1);
    return fits[$urandom_range(fits.size() - 1)];
  endfunction

  // Most pixels are aimed at the window so that frames collect real objects;
  // the rest are arbitrary noise.
  function automatic logic [PIX_W-1:0] make_pixel();
    if ($urandom_range(9) < 7)
      return {5'(pick_channel(0)), 6'(pick_channel(1)), 5'(pick_channel(2))};
    return 16'($urandom);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(9))
      0:       return '0;
      1:       return COORD_MAX;
      default: return 10'($urandom);
    endcase
  endfunction

  // A random window: mostly an ordinary span, sometimes fully open, and
  // sometimes empty, either with low equal to high or with the two reversed.
  task automatic random_window(output logic [CHAN_W-1:0] lo, hi);
    int upper;
    case ($urandom_range(9))
      0: begin
        lo = 8'd0;
        hi = 8'd255;
      end
      1: begin
        lo = 8'($urandom);
        hi = lo;
      end
      2: begin
        lo = 8'd255;
        hi = 8'd0;
      end
      default: begin
        lo = 8'($urandom_range(0, 200));
        upper = lo + $urandom_range(2, 100);
        hi = (upper > 255) ? 8'd255 : 8'(upper);
      end
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_min_count();
    case ($urandom_range(11))
      0:       return '0;
      1:       return COUNT_MAX;
      2:       return 21'($urandom);
      default: return 21'($urandom_range(0, 12));
    endcase
  endfunction

  task automatic send_frame(input int len);
    int i;
    for (i = 0; i < len; i++)
      send_beat(make_pixel(), pick_coord(), pick_coord(), i == len - 1);
  endtask

  initial begin
    logic [CHAN_W-1:0]     r_lo, r_hi, g_lo, g_hi, b_lo, b_hi;
    logic [CFG_DATA_W-1:0] min_count;
    int                    phase;
    int                    sent;
    int                    frame_len;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.pixel_value  = '0;
    in_ch.row          = '0;
    in_ch.column       = '0;
    in_ch.end_of_frame = 1'b0;
    out_ch.ready       = 1'b0;
    stall_tick         = '0;
    chan_lo = '{RED_LOW_RST, GREEN_LOW_RST, BLUE_LOW_RST};
    chan_hi = '{RED_HIGH_RST, GREEN_HIGH_RST, BLUE_HIGH_RST};

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Default windows after reset: red (60,100), green (0,40), blue (20,60),
    // and an object needs more than 100 matches.
    send_beat({5'd10, 6'd5, 5'd5}, 10'd0, 10'd0, 1'b0);
    // The largest and the smallest codes that still fit each window.
    send_beat({5'd12, 6'd9, 5'd7}, 10'd1023, 10'd1023, 1'b0);
    send_beat({5'd8, 6'd1, 5'd3}, 10'd512, 10'd256, 1'b0);
    // Red just below and just above its window.
    send_beat({5'd7, 6'd5, 5'd5}, 10'd3, 10'd4, 1'b0);
    send_beat({5'd13, 6'd5, 5'd5}, 10'd5, 10'd6, 1'b0);
    // Green sitting exactly on each bound must not match, since both are strict.
    send_beat({5'd10, 6'd0, 5'd5}, 10'd7, 10'd8, 1'b0);
    send_beat({5'd10, 6'd10, 5'd5}, 10'd9, 10'd10, 1'b0);
    send_beat(16'h0000, 10'd0, 10'd0, 1'b0);
    send_beat(16'hFFFF, 10'd1023, 10'd1023, 1'b0);
    // Four matches are too few for an object: only the count is reported.
    send_beat({5'd9, 6'd2, 5'd6}, 10'd700, 10'd300, 1'b1);
    // A frame of one grey pixel reports a count of zero.
    send_beat(16'hFFFF, 10'd5, 10'd5, 1'b1);

    // Fully open windows and no minimum. A zero channel still fails because
    // it equals the low bound; full white still passes below 255.
    apply_settings(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, '0);
    send_beat(16'h0821, 10'd1023, 10'd0, 1'b0);
    send_beat(16'hFFFF, 10'd1022, 10'd1, 1'b0);
    send_beat(16'h0000, 10'd0, 10'd0, 1'b0);
    send_beat(16'h0821, 10'd1, 10'd1023, 1'b1);

    // Red window with no room between its bounds: nothing can match.
    apply_settings(8'd100, 8'd101, 8'd0, 8'd255, 8'd0, 8'd255, 21'd2);
    send_beat(16'hFFFF, 10'd10, 10'd20, 1'b0);
    send_beat({5'd12, 6'd9, 5'd9}, 10'd30, 10'd40, 1'b1);

    // Every window reversed and the largest minimum count.
    apply_settings(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, COUNT_MAX);
    send_beat(16'h5A5A, 10'd300, 10'd400, 1'b0);
    send_beat(16'hA5A5, 10'd301, 10'd401, 1'b1);

    // A red window that admits one code only. One match equals the minimum
    // and reports no object; two matches exceed it and give a centroid.
    apply_settings(8'd63, 8'd65, 8'd0, 8'd255, 8'd0, 8'd255, 21'd1);
    send_beat({5'd8, 6'd20, 5'd20}, 10'd100, 10'd200, 1'b1);
    send_beat({5'd8, 6'd63, 5'd31}, 10'd1023, 10'd1023, 1'b0);
    send_beat({5'd8, 6'd1, 5'd1}, 10'd0, 10'd0, 1'b1);

    // Random part: each phase picks new windows and a new minimum, then sends
    // whole frames, mostly short ones with now and then a long one.
    for (phase = 0; phase < PHASES; phase++) begin
      random_window(r_lo, r_hi);
      random_window(g_lo, g_hi);
      random_window(b_lo, b_hi);
      min_count = random_min_count();
      apply_settings(r_lo, r_hi, g_lo, g_hi, b_lo, b_hi, min_count);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        frame_len = ($urandom_range(7) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
        send_frame(frame_len);
        sent += frame_len;
      end
    end

    // Let the last results drain, then allow for anything stray that the
    // block might still emit after its longest division.
    wait_results_done();
    repeat (60) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS color_threshold_centroid");
    end else begin
      $display("FAIL color_threshold_centroid");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #20ms;
    $display("FAIL color_threshold_centroid");
    $finish;
  end

endmodule
